// ===== rtl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared constants, codes and types of the sorted table floor search block.
// ----------------------------------------------------------------------------
package sfs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 11;
	localparam int COORD_W     = 32;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
	localparam logic [1:0] REG_RANGE_LOW   = 2'd1;
	localparam logic [1:0] REG_RANGE_HIGH  = 2'd2;

	// item commands
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0]          last_idx;
		logic signed [COORD_W-1:0] range_low;
		logic signed [COORD_W-1:0] range_high;
	} sfs_cfg_t;

endpackage

// ===== rtl/sfs_regs.sv =====
// ----------------------------------------------------------------------------
// sfs_regs
// Configuration registers on the APB port; derives the last valid index.
// ----------------------------------------------------------------------------
module sfs_regs
	import sfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output sfs_cfg_t          cfg
);

	logic [CNT_W-1:0]   entry_count_q;
	logic [COORD_W-1:0] range_low_q;
	logic [COORD_W-1:0] range_high_q;
	logic               wr_en;
	logic [1:0]         reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= CNT_W'(1);
			range_low_q   <= '0;
			range_high_q  <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ENTRY_COUNT: entry_count_q <= pwdata[CNT_W-1:0];
				REG_RANGE_LOW:   range_low_q   <= pwdata[COORD_W-1:0];
				REG_RANGE_HIGH:  range_high_q  <= pwdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_ENTRY_COUNT: prdata = DATA_W'(entry_count_q);
			REG_RANGE_LOW:   prdata = range_low_q;
			REG_RANGE_HIGH:  prdata = range_high_q;
			default:         prdata = '0;
		endcase
	end

	// zero entries count as one, too many saturate at the table depth
	always_comb begin
		priority if (entry_count_q == '0)
			cfg.last_idx = '0;
		else if (entry_count_q > CNT_W'(TABLE_DEPTH))
			cfg.last_idx = IDX_W'(TABLE_DEPTH - 1);
		else
			cfg.last_idx = IDX_W'(entry_count_q - CNT_W'(1));
		cfg.range_low  = $signed(range_low_q);
		cfg.range_high = $signed(range_high_q);
	end

endmodule

// ===== rtl/sorted_table_floor_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_floor_search
// Table of ascending Q16.16 coordinates with a bisecting floor search.
// ----------------------------------------------------------------------------
// Write items (cmd 0) store coord at slot and give no result. A search item
// (cmd 1) returns the index of the entry at or just below the query, clamped
// to 0 below range_low and to the last entry above range_high. In range, the
// last entry is never picked (unless it is the only one) and 0 is the floor.
// All comparisons go through one signed 32-bit comparator under a small
// sequencer: the range checks (the high check skipped when the query is below
// range_low), then bisection steps of a table read and a compare, up to ten
// steps with the 1024-entry table, a last read that ends the bisection, a
// load of the result once the output is free, and a return to idle. The
// registered table read gives each step its own read state. in_ready is low
// while a search is in progress; a finished result waits in the output
// register as the next item enters. Table entries are undefined until written.
module sorted_table_floor_search
	import sfs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [IDX_W-1:0]          slot,
	input  logic signed [COORD_W-1:0] coord,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [IDX_W-1:0]          found_index
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHK_LO = 3'd1;
	localparam logic [2:0] ST_CHK_HI = 3'd2;
	localparam logic [2:0] ST_ADDR   = 3'd3;
	localparam logic [2:0] ST_CMP    = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	sfs_cfg_t cfg;

	logic [2:0]                state_q;
	logic [IDX_W-1:0]          lo_q;
	logic [IDX_W-1:0]          hi_q;
	logic [IDX_W-1:0]          mid_q;
	logic [IDX_W-1:0]          res_q;
	logic signed [COORD_W-1:0] query_q;
	logic [COORD_W-1:0]        rd_data_q;
	logic [COORD_W-1:0]        table_mem [TABLE_DEPTH];
	logic                      out_valid_q;
	logic [IDX_W-1:0]          found_index_q;

	logic                      in_fire;
	logic                      out_load;
	logic [IDX_W-1:0]          span;
	logic [IDX_W-1:0]          mid;
	logic signed [COORD_W-1:0] op_a;
	logic signed [COORD_W-1:0] op_b;
	logic                      a_gt_b;

	sfs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_ready    = (state_q == ST_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign found_index = found_index_q;

	assign span = hi_q - lo_q;
	assign mid  = lo_q + (span >> 1);

	// shared comparator: range_low > q, q > range_high, entry > q
	always_comb begin
		unique case (state_q)
			ST_CHK_LO: begin
				op_a = cfg.range_low;
				op_b = query_q;
			end
			ST_CHK_HI: begin
				op_a = query_q;
				op_b = cfg.range_high;
			end
			default: begin
				op_a = $signed(rd_data_q);
				op_b = query_q;
			end
		endcase
	end
	assign a_gt_b = op_a > op_b;

	always_ff @(posedge clk) begin
		if (in_fire && cmd == CMD_WRITE)
			table_mem[slot] <= coord;
		rd_data_q <= table_mem[mid];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:   if (in_fire && cmd == CMD_SEARCH) state_q <= ST_CHK_LO;
				ST_CHK_LO: state_q <= a_gt_b ? ST_DONE : ST_CHK_HI;
				ST_CHK_HI: state_q <= a_gt_b ? ST_DONE : ST_ADDR;
				ST_ADDR:   state_q <= (span > IDX_W'(1)) ? ST_CMP : ST_DONE;
				ST_CMP:    state_q <= ST_ADDR;
				ST_DONE:   if (out_load) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				query_q <= coord;
				lo_q    <= '0;
				hi_q    <= cfg.last_idx;
			end
			ST_CHK_LO: res_q <= '0;
			ST_CHK_HI: res_q <= cfg.last_idx;
			ST_ADDR: begin
				mid_q <= mid;
				res_q <= lo_q;
			end
			ST_CMP: begin
				// move the upper bound when the probed entry exceeds the query
				if (a_gt_b)
					hi_q <= mid_q;
				else
					lo_q <= mid_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			found_index_q <= res_q;
	end

	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDR || state_q == ST_CMP) |-> lo_q <= hi_q)
		else $error("bisection bounds crossed");

	a_result_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> res_q <= cfg.last_idx)
		else $error("result beyond last valid entry");

	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd == CMD_SEARCH) |=> state_q == ST_CHK_LO)
		else $error("search item did not start range check");

	a_probe_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> $past(state_q) == ST_ADDR)
		else $error("compare without table read");

endmodule

// ===== bench/sorted_table_floor_search_chk.sv =====
// ----------------------------------------------------------------------------
// sorted_table_floor_search_chk
// Watches the register port and both item channels of the floor search block,
// keeps its own copy of the table and the registers, predicts found_index for
// every accepted search and compares it with the results as they leave.
// ----------------------------------------------------------------------------
module sorted_table_floor_search_chk
	import sfs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	input  logic                      pready,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      cmd,
	input  logic [IDX_W-1:0]          slot,
	input  logic signed [COORD_W-1:0] coord,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [IDX_W-1:0]          found_index,
	output int                        fail_count,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [COORD_W-1:0] coord_mem [TABLE_DEPTH];
	logic [CNT_W-1:0]          count_reg = CNT_W'(1);
	logic signed [COORD_W-1:0] low_reg   = '0;
	logic signed [COORD_W-1:0] high_reg  = '0;
	logic [IDX_W-1:0]          floor_q [$];
	int                        mismatches = 0;

	assign fail_count = mismatches;

	function automatic logic [IDX_W-1:0] floor_index_of(input logic signed [COORD_W-1:0] q);
		int unsigned n, lo, hi, mid;
		n = 32'(count_reg);
		if (n == 0)
			n = 1;
		if (n > TABLE_DEPTH)
			n = TABLE_DEPTH;
		// below-range test first: it wins when the range is crossed
		if (q < low_reg)
			return '0;
		if (q > high_reg)
			return IDX_W'(n - 1);
		lo = 0;
		hi = n - 1;
		while (hi - lo > 1) begin
			mid = lo + (hi - lo) / 2;
			if (coord_mem[IDX_W'(mid)] > q)
				hi = mid;
			else
				lo = mid;
		end
		return IDX_W'(lo);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [IDX_W-1:0] want;
		if (!arst_n) begin
			count_reg = CNT_W'(1);
			low_reg   = '0;
			high_reg  = '0;
			floor_q.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_ENTRY_COUNT: count_reg = pwdata[CNT_W-1:0];
					REG_RANGE_LOW:   low_reg   = pwdata[COORD_W-1:0];
					REG_RANGE_HIGH:  high_reg  = pwdata[COORD_W-1:0];
					default: ;
				endcase
			end
			// retire before admitting: a new search cannot finish in the cycle it enters
			if (out_valid && out_ready) begin
				if (floor_q.size() == 0) begin
					report_mismatch($sformatf("found_index %0d with no search outstanding",
						found_index));
				end else begin
					want = floor_q.pop_front();
					if (found_index !== want)
						report_mismatch($sformatf("found_index %0d, expected %0d",
							found_index, want));
				end
			end
			if (in_valid && in_ready) begin
				if (cmd == CMD_SEARCH)
					floor_q.push_back(floor_index_of(coord));
				else
					coord_mem[slot] = coord;
			end
			pending <= floor_q.size();
		end
	end

endmodule

// ===== bench/sorted_table_floor_search_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_table_floor_search_tb
// Drives the floor search block: a directed pass over the corner cases, then
// phases that set the registers, load an ascending table and issue searches,
// under changing idle patterns on both channels. Checking is in the checker.
// ----------------------------------------------------------------------------
module sorted_table_floor_search_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sfs_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int RANDOM_ITEMS = 240;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      psel      = 1'b0;
	logic                      penable   = 1'b0;
	logic                      pwrite    = 1'b0;
	logic [ADDR_W-1:0]         paddr     = '0;
	logic [DATA_W-1:0]         pwdata    = '0;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	logic                      cmd       = CMD_WRITE;
	logic [IDX_W-1:0]          slot      = '0;
	logic signed [COORD_W-1:0] coord     = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [IDX_W-1:0]          found_index;
	int                        fail_count;
	int                        pending;

	int unsigned               src_idle_pct  = 0;
	int unsigned               sink_idle_pct = 0;
	int unsigned               sent_items    = 0;
	int                        stall_cycles  = 0;
	logic signed [COORD_W-1:0] table_plan [TABLE_DEPTH];

	sorted_table_floor_search dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .slot(slot), .coord(coord),
		.out_valid(out_valid), .out_ready(out_ready), .found_index(found_index)
	);

	sorted_table_floor_search_chk chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .slot(slot), .coord(coord),
		.out_valid(out_valid), .out_ready(out_ready), .found_index(found_index),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic logic signed [COORD_W-1:0] sat32(input longint v);
		if (v > Q_MAX)
			return C_MAX;
		if (v < Q_MIN)
			return C_MIN;
		return v[COORD_W-1:0];
	endfunction

	task automatic send_item(input logic c, input logic [IDX_W-1:0] s,
			input logic signed [COORD_W-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		slot     <= s;
		coord    <= v;
		do @(posedge clk); while (!in_ready);
		if (c == CMD_WRITE)
			table_plan[s] = v;
		sent_items++;
	endtask

	// hold the input until every search has answered, then optionally let the block settle
	task automatic hold_until_drained(input bit settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		if (settle)
			repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_registers(input logic [DATA_W-1:0] cnt,
			input logic signed [COORD_W-1:0] lo, input logic signed [COORD_W-1:0] hi);
		hold_until_drained(1'b1);
		reg_write(REG_ENTRY_COUNT, cnt);
		reg_write(REG_RANGE_LOW, lo);
		reg_write(REG_RANGE_HIGH, hi);
	endtask

	task automatic run_phase(input int unsigned n_cfg, input bit reload,
			input int unsigned n_search);
		int unsigned               n, i, k, r;
		longint                    acc;
		logic signed [COORD_W-1:0] lo_v, hi_v, q;
		n = (n_cfg == 0) ? 1 : ((n_cfg > TABLE_DEPTH) ? TABLE_DEPTH : n_cfg);
		if (reload) begin
			// ascending values with some repeats; large tables start low to stay in range
			if (n > 64)
				acc = Q_MIN + longint'($urandom_range(0, 1 << 29));
			else if ($urandom_range(9) == 0)
				acc = Q_MIN;
			else
				acc = longint'(int'($urandom())) / 2;
			for (i = 0; i < n; i++) begin
				table_plan[IDX_W'(i)] = sat32(acc);
				if ($urandom_range(3) != 0)
					acc += $urandom_range(1, 1 << 20);
			end
		end
		r = $urandom_range(99);
		if (r < 60) begin
			lo_v = table_plan[0];
			hi_v = table_plan[IDX_W'(n - 1)];
		end else if (r < 75) begin
			lo_v = sat32(longint'(table_plan[0]) - $urandom_range(0, 4096));
			hi_v = sat32(longint'(table_plan[IDX_W'(n - 1)]) + $urandom_range(0, 4096));
		end else if (r < 85) begin
			lo_v = table_plan[IDX_W'(n - 1)];
			hi_v = table_plan[0];
		end else if (r < 93) begin
			lo_v = C_MIN;
			hi_v = C_MAX;
		end else begin
			lo_v = $urandom();
			hi_v = $urandom();
		end
		set_registers(n_cfg, lo_v, hi_v);
		if (reload) begin
			for (i = 0; i < n; i++) begin
				if (n < TABLE_DEPTH && $urandom_range(9) == 0)
					send_item(CMD_WRITE, IDX_W'($urandom_range(n, TABLE_DEPTH - 1)),
						$urandom());
				send_item(CMD_WRITE, IDX_W'(i), table_plan[IDX_W'(i)]);
			end
		end
		for (k = 0; k < n_search; k++) begin
			r = $urandom_range(99);
			i = $urandom_range(0, n - 1);
			if (r < 5) begin
				// break the ordering of a live entry
				send_item(CMD_WRITE, IDX_W'(i), $urandom());
			end else begin
				if (r < 35) begin
					q = table_plan[IDX_W'(i)];
				end else if (r < 60) begin
					q = sat32(longint'(table_plan[IDX_W'(i)]) + $urandom_range(1, 1 << 20));
				end else if (r < 70) begin
					case ($urandom_range(3))
						0:       q = sat32(longint'(lo_v) - 1);
						1:       q = lo_v;
						2:       q = hi_v;
						default: q = sat32(longint'(hi_v) + 1);
					endcase
				end else if (r < 90) begin
					q = $urandom();
				end else begin
					q = $urandom_range(1) ? C_MAX : C_MIN;
				end
				if ($urandom_range(15) == 0)
					hold_until_drained(1'b0);
				send_item(CMD_SEARCH, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), q);
			end
		end
	endtask

	initial begin
		int unsigned i, r, n_cfg, start;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single entry at reset settings, extreme slots and coordinates
		send_item(CMD_WRITE, '0, C_MIN);
		send_item(CMD_WRITE, '1, C_MAX);
		send_item(CMD_SEARCH, '0, '0);
		send_item(CMD_SEARCH, '1, C_MIN);
		send_item(CMD_SEARCH, '0, C_MAX);

		// zero entries behaves as one
		set_registers(0, C_MIN, C_MAX);
		send_item(CMD_SEARCH, '0, '0);
		send_item(CMD_SEARCH, '0, C_MAX);

		for (i = 0; i < 4; i++)
			send_item(CMD_WRITE, IDX_W'(i), COORD_W'(i << 16));

		// query on the last entry lands one below it
		set_registers(4, '0, 32'sh0003_0000);
		send_item(CMD_SEARCH, '0, 32'sh0003_0000);
		send_item(CMD_SEARCH, '0, 32'sh0001_8000);
		send_item(CMD_SEARCH, '0, '0);
		send_item(CMD_SEARCH, '0, -32'sd1);
		send_item(CMD_SEARCH, '0, 32'sh0003_0001);

		// crossed range
		set_registers(4, 32'sh0002_0000, 32'sh0001_0000);
		send_item(CMD_SEARCH, '0, 32'sh0001_8000);
		send_item(CMD_SEARCH, '0, 32'sh0003_0000);

		start = sent_items;
		while (sent_items - start < RANDOM_ITEMS) begin
			if (sent_items - start < RANDOM_ITEMS / 3) begin
				src_idle_pct  = 10;
				sink_idle_pct = 88;
			end else if (sent_items - start < 2 * RANDOM_ITEMS / 3) begin
				src_idle_pct  = 88;
				sink_idle_pct = 10;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			r = $urandom_range(99);
			n_cfg = (r < 4) ? 0 : ((r < 8) ? 1 : $urandom_range(2, 48));
			run_phase(n_cfg, 1'b1, $urandom_range(4, 24));
		end

		// full table, then a count beyond the depth over the same contents
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		run_phase(TABLE_DEPTH, 1'b1, 40);
		run_phase(2047, 1'b0, 40);

		hold_until_drained(1'b0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sfs_pkg.sv
rtl/sfs_regs.sv
rtl/sorted_table_floor_search.sv
bench/sorted_table_floor_search_chk.sv
bench/sorted_table_floor_search_tb.sv
